### rtl/core/fru_pkg.sv
// fru_pkg: shared types, stage counts and width helpers for the fresnel reflectance unit
// used by fru_cond_prep, fru_finish and the top level; depends on nothing
`timescale 1ns / 1ps

package fru_pkg;

  localparam int FRU_ETA_FRAC_BITS = 12;

  // stage counts of the pipeline sections
  localparam int FRU_FRONT_STAGES = 2;
  localparam int FRU_QW1          = 30;
  localparam int FRU_RW           = 16;
  localparam int FRU_PREP_STAGES  = 5;
  localparam int FRU_QW2          = 33;
  localparam int FRU_FIN_STAGES   = 2;

  typedef enum logic {
    FRU_OP_DIELECTRIC = 1'b0,
    FRU_OP_CONDUCTOR  = 1'b1
  } fru_op_t;

  typedef struct packed {
    fru_op_t            op;
    logic               tir;
    logic signed [15:0] c;
    logic [15:0]        ei;
    logic [15:0]        et;
    logic [15:0]        er;
    logic [15:0]        k;
  } fru_front_t;

  typedef struct packed {
    fru_op_t op;
    logic    tir;
    logic    cz;
    logic    cap_a;
    logic    cap_b;
    logic    sz_a;
    logic    sz_b;
  } fru_back_t;

  localparam int FRU_FRONT_W = $bits(fru_front_t);
  localparam int FRU_BACK_W  = $bits(fru_back_t);

  // signed width that holds eta*c +- 1 and eta +- 2c in Q16
  function automatic int fru_mag_w(input int frac_bits);
    int ew;
    ew = 33 - frac_bits;
    return ((ew > 17) ? ew : 17) + 2;
  endfunction

endpackage

### rtl/core/fru_div_pipe.sv
// fru_div_pipe: pipelined restoring divider, one quotient bit per stage
// generic; needs num_i[top DW bits] below den_i for an exact quotient
`timescale 1ns / 1ps

module fru_div_pipe #(
  parameter int DW = 32,
  parameter int QW = 30,
  parameter int SW = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             vld_i,
  input  logic [DW+QW-1:0] num_i,
  input  logic [DW-1:0]    den_i,
  input  logic [SW-1:0]    side_i,
  output logic             vld_o,
  output logic [QW-1:0]    quo_o,
  output logic [SW-1:0]    side_o
);

  logic          vld_r  [QW];
  logic [DW-1:0] rem_r  [QW];
  logic [QW-1:0] low_r  [QW];
  logic [DW-1:0] den_r  [QW];
  logic [SW-1:0] side_r [QW];

  genvar g;
  for (g = 0; g < QW; g++) begin : g_stage
    logic          vld_in;
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] low_in;
    logic [SW-1:0] side_in;
    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_nxt;
    logic [QW-1:0] low_nxt;

    if (g == 0) begin : g_head
      assign vld_in  = vld_i;
      assign rem_in  = num_i[DW+QW-1:QW];
      assign low_in  = num_i[QW-1:0];
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_body
      assign vld_in  = vld_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign low_in  = low_r[g-1];
      assign den_in  = den_r[g-1];
      assign side_in = side_r[g-1];
    end

    assign trial   = {rem_in, low_in[QW-1]};
    assign ge      = trial >= {1'b0, den_in};
    assign rem_nxt = ge ? DW'(trial - {1'b0, den_in}) : DW'(trial);
    assign low_nxt = {low_in[QW-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else begin
        vld_r[g] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[g]  <= rem_nxt;
      low_r[g]  <= low_nxt;
      den_r[g]  <= den_in;
      side_r[g] <= side_in;
    end
  end

  assign vld_o  = vld_r[QW-1];
  assign quo_o  = low_r[QW-1];
  assign side_o = side_r[QW-1];

endmodule

### rtl/core/fru_isqrt_pipe.sv
// fru_isqrt_pipe: pipelined integer square root, one root bit per stage
// generic; floor root of a 2*RW bit radicand
`timescale 1ns / 1ps

module fru_isqrt_pipe #(
  parameter int RW = 16,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            vld_i,
  input  logic [2*RW-1:0] rad_i,
  input  logic [SW-1:0]   side_i,
  output logic            vld_o,
  output logic [RW-1:0]   root_o,
  output logic [SW-1:0]   side_o
);

  logic            vld_r  [RW];
  logic [RW+1:0]   rem_r  [RW];
  logic [RW-1:0]   root_r [RW];
  logic [2*RW-1:0] rad_r  [RW];
  logic [SW-1:0]   side_r [RW];

  genvar g;
  for (g = 0; g < RW; g++) begin : g_stage
    logic            vld_in;
    logic [RW+1:0]   rem_in;
    logic [RW-1:0]   root_in;
    logic [2*RW-1:0] rad_in;
    logic [SW-1:0]   side_in;
    logic [RW+3:0]   acc;
    logic [RW+3:0]   trial;
    logic            ge;
    logic [RW+1:0]   rem_nxt;
    logic [RW-1:0]   root_nxt;
    logic [2*RW-1:0] rad_nxt;

    if (g == 0) begin : g_head
      assign vld_in  = vld_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_body
      assign vld_in  = vld_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign root_in = root_r[g-1];
      assign rad_in  = rad_r[g-1];
      assign side_in = side_r[g-1];
    end

    assign acc      = {rem_in, rad_in[2*RW-1 -: 2]};
    assign trial    = {2'b00, root_in, 2'b01};
    assign ge       = acc >= trial;
    assign rem_nxt  = ge ? (RW+2)'(acc - trial) : (RW+2)'(acc);
    assign root_nxt = {root_in[RW-2:0], ge};
    assign rad_nxt  = {rad_in[2*RW-3:0], 2'b00};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else begin
        vld_r[g] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[g]  <= rem_nxt;
      root_r[g] <= root_nxt;
      rad_r[g]  <= rad_nxt;
      side_r[g] <= side_in;
    end
  end

  assign vld_o  = vld_r[RW-1];
  assign root_o = root_r[RW-1];
  assign side_o = side_r[RW-1];

endmodule

### rtl/core/fru_cond_prep.sv
// fru_cond_prep: five stages that build the numerators and denominators of both ratios
// dielectric amplitude ratios and conductor squared ratios; depends on fru_pkg
`timescale 1ns / 1ps

module fru_cond_prep import fru_pkg::*; #(
  parameter int ETA_FRAC_BITS = FRU_ETA_FRAC_BITS,
  localparam int E16W = 32 - ETA_FRAC_BITS,
  localparam int EW   = E16W + 1,
  localparam int MW   = fru_mag_w(ETA_FRAC_BITS),
  localparam int DW   = 2 * MW + 1,
  localparam int NW   = DW + FRU_QW2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              vld_i,
  input  logic [FRU_RW-1:0] cost_i,
  input  fru_front_t        front_i,
  output logic              vld_o,
  output logic [NW-1:0]     num_a_o,
  output logic [DW-1:0]     den_a_o,
  output logic [NW-1:0]     num_b_o,
  output logic [DW-1:0]     den_b_o,
  output fru_back_t         back_o
);

  localparam logic signed [MW-1:0] ONE_Q16 = MW'(65536);
  localparam int COND_FRAC = 32;
  localparam int DIEL_FRAC = 31;

  // stage 1: products
  logic [15:0]          ci;
  logic [E16W-1:0]      e16;
  logic [E16W-1:0]      k16;
  logic [4:0]           p1_vld_r;
  fru_op_t              p1_op_r;
  logic                 p1_tir_r;
  logic [31:0]          p1_a1_r, p1_b1_r, p1_a2_r, p1_b2_r;
  logic [E16W+15:0]     p1_ecm_r, p1_kcm_r;
  logic [E16W-1:0]      p1_e16_r, p1_k16_r;
  logic signed [15:0]   p1_c_r;

  assign ci  = front_i.c[15] ? 16'($unsigned(-front_i.c)) : $unsigned(front_i.c);
  assign e16 = E16W'({front_i.er, 16'b0} >> ETA_FRAC_BITS);
  assign k16 = E16W'({front_i.k, 16'b0} >> ETA_FRAC_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= '0;
    end else begin
      p1_vld_r <= {p1_vld_r[3:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    p1_op_r  <= front_i.op;
    p1_tir_r <= front_i.tir;
    p1_a1_r  <= 32'(front_i.et) * 32'(ci);
    p1_b1_r  <= 32'(front_i.ei) * 32'(cost_i);
    p1_a2_r  <= 32'(front_i.ei) * 32'(ci);
    p1_b2_r  <= 32'(front_i.et) * 32'(cost_i);
    p1_ecm_r <= (E16W+16)'(e16) * (E16W+16)'(ci);
    p1_kcm_r <= (E16W+16)'(k16) * (E16W+16)'(ci);
    p1_e16_r <= e16;
    p1_k16_r <= k16;
    p1_c_r   <= front_i.c;
  end

  // stage 2: differences and sums
  logic [EW-1:0]        ecmag;
  logic signed [MW-1:0] ecu, ecs, c16, e16s;
  fru_op_t              p2_op_r;
  logic                 p2_tir_r;
  logic [31:0]          p2_dd1_r, p2_dd2_r;
  logic [32:0]          p2_ss1_r, p2_ss2_r;
  logic signed [MW-1:0] p2_x1_r, p2_x2_r, p2_y1_r, p2_y2_r;
  logic [EW-1:0]        p2_kc_r;
  logic [E16W-1:0]      p2_k16_r;

  assign ecmag = EW'(p1_ecm_r >> 15);
  assign ecu   = $signed(MW'(ecmag));
  assign ecs   = (p1_c_r < 0) ? -ecu : ecu;
  assign c16   = MW'(p1_c_r) <<< 1;
  assign e16s  = $signed(MW'(p1_e16_r));

  always_ff @(posedge clk) begin
    p2_op_r  <= p1_op_r;
    p2_tir_r <= p1_tir_r;
    p2_dd1_r <= (p1_a1_r >= p1_b1_r) ? p1_a1_r - p1_b1_r : p1_b1_r - p1_a1_r;
    p2_dd2_r <= (p1_a2_r >= p1_b2_r) ? p1_a2_r - p1_b2_r : p1_b2_r - p1_a2_r;
    p2_ss1_r <= 33'(p1_a1_r) + 33'(p1_b1_r);
    p2_ss2_r <= 33'(p1_a2_r) + 33'(p1_b2_r);
    p2_x1_r  <= ecs - ONE_Q16;
    p2_x2_r  <= ecs + ONE_Q16;
    p2_y1_r  <= e16s - c16;
    p2_y2_r  <= e16s + c16;
    p2_kc_r  <= EW'(p1_kcm_r >> 15);
    p2_k16_r <= p1_k16_r;
  end

  // stage 3: squares
  fru_op_t           p3_op_r;
  logic              p3_tir_r;
  logic [31:0]       p3_dd1_r, p3_dd2_r;
  logic [32:0]       p3_ss1_r, p3_ss2_r;
  logic [2*MW-1:0]   p3_x1s_r, p3_x2s_r, p3_y1s_r, p3_y2s_r, p3_kc2_r, p3_k2_r;

  always_ff @(posedge clk) begin
    p3_op_r  <= p2_op_r;
    p3_tir_r <= p2_tir_r;
    p3_dd1_r <= p2_dd1_r;
    p3_dd2_r <= p2_dd2_r;
    p3_ss1_r <= p2_ss1_r;
    p3_ss2_r <= p2_ss2_r;
    p3_x1s_r <= $unsigned((2*MW)'(p2_x1_r) * (2*MW)'(p2_x1_r));
    p3_x2s_r <= $unsigned((2*MW)'(p2_x2_r) * (2*MW)'(p2_x2_r));
    p3_y1s_r <= $unsigned((2*MW)'(p2_y1_r) * (2*MW)'(p2_y1_r));
    p3_y2s_r <= $unsigned((2*MW)'(p2_y2_r) * (2*MW)'(p2_y2_r));
    p3_kc2_r <= (2*MW)'(p2_kc_r) * (2*MW)'(p2_kc_r);
    p3_k2_r  <= (2*MW)'(p2_k16_r) * (2*MW)'(p2_k16_r);
  end

  // stage 4: numerators and denominators
  fru_op_t     p4_op_r;
  logic        p4_tir_r;
  logic [31:0] p4_dd1_r, p4_dd2_r;
  logic [32:0] p4_ss1_r, p4_ss2_r;
  logic [DW-1:0] p4_n1_r, p4_d1_r, p4_n2_r, p4_d2_r;

  always_ff @(posedge clk) begin
    p4_op_r  <= p3_op_r;
    p4_tir_r <= p3_tir_r;
    p4_dd1_r <= p3_dd1_r;
    p4_dd2_r <= p3_dd2_r;
    p4_ss1_r <= p3_ss1_r;
    p4_ss2_r <= p3_ss2_r;
    p4_n1_r  <= DW'(p3_x1s_r) + DW'(p3_kc2_r);
    p4_d1_r  <= DW'(p3_x2s_r) + DW'(p3_kc2_r);
    p4_n2_r  <= DW'(p3_y1s_r) + DW'(p3_k2_r);
    p4_d2_r  <= DW'(p3_y2s_r) + DW'(p3_k2_r);
  end

  // stage 5: divider operands and flags
  logic          cond;
  logic [NW-1:0] num_a_nxt, num_b_nxt;
  logic [DW-1:0] den_a_nxt, den_b_nxt;
  fru_back_t     back_nxt;
  logic [NW-1:0] num_a_r, num_b_r;
  logic [DW-1:0] den_a_r, den_b_r;
  fru_back_t     back_r;

  always_comb begin
    cond          = p4_op_r == FRU_OP_CONDUCTOR;
    num_a_nxt     = cond ? NW'(p4_n1_r) << COND_FRAC : NW'(p4_dd1_r) << DIEL_FRAC;
    num_b_nxt     = cond ? NW'(p4_n2_r) << COND_FRAC : NW'(p4_dd2_r) << DIEL_FRAC;
    den_a_nxt     = cond ? p4_d1_r : DW'(p4_ss1_r);
    den_b_nxt     = cond ? p4_d2_r : DW'(p4_ss2_r);
    back_nxt.op    = p4_op_r;
    back_nxt.tir   = p4_tir_r;
    back_nxt.cz    = (p4_d1_r == '0) || (p4_d2_r == '0);
    back_nxt.cap_a = (DW+1)'(p4_n1_r) >= {p4_d1_r, 1'b0};
    back_nxt.cap_b = (DW+1)'(p4_n2_r) >= {p4_d2_r, 1'b0};
    back_nxt.sz_a  = p4_ss1_r == '0;
    back_nxt.sz_b  = p4_ss2_r == '0;
  end

  always_ff @(posedge clk) begin
    num_a_r <= num_a_nxt;
    num_b_r <= num_b_nxt;
    den_a_r <= den_a_nxt;
    den_b_r <= den_b_nxt;
    back_r  <= back_nxt;
  end

  assign vld_o   = p1_vld_r[4];
  assign num_a_o = num_a_r;
  assign num_b_o = num_b_r;
  assign den_a_o = den_a_r;
  assign den_b_o = den_b_r;
  assign back_o  = back_r;

endmodule

### rtl/core/fru_finish.sv
// fru_finish: squares or sums the two ratios, rounds to Q0.16 and saturates
// last two stages and the result registers; depends on fru_pkg
`timescale 1ns / 1ps

module fru_finish import fru_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               vld_i,
  input  logic [FRU_QW2-1:0] qa_i,
  input  logic [FRU_QW2-1:0] qb_i,
  input  fru_back_t          back_i,
  output logic               vld_o,
  output logic [15:0]        refl_o,
  output logic               tr_o
);

  localparam logic [31:0] DIEL_ONE = 32'h8000_0000;
  localparam logic [33:0] COND_CAP = 34'h2_0000_0000;

  logic [31:0] ra, rb;
  logic [33:0] ca, cb;
  logic        f1_vld_r;
  fru_back_t   f1_back_r;
  logic [63:0] f1_sqa_r, f1_sqb_r;
  logic [34:0] f1_csum_r;

  assign ra = back_i.sz_a ? DIEL_ONE : qa_i[31:0];
  assign rb = back_i.sz_b ? DIEL_ONE : qb_i[31:0];
  assign ca = back_i.cap_a ? COND_CAP : 34'(qa_i);
  assign cb = back_i.cap_b ? COND_CAP : 34'(qb_i);

  always_ff @(posedge clk) begin
    f1_back_r <= back_i;
    f1_sqa_r  <= 64'(ra) * 64'(ra);
    f1_sqb_r  <= 64'(rb) * 64'(rb);
    f1_csum_r <= 35'(ca) + 35'(cb);
  end

  logic [64:0] dsum;
  logic [35:0] csum;
  logic [17:0] dval;
  logic [18:0] cval;
  logic [15:0] refl_nxt;
  logic        tr_nxt;
  logic        vld_r;
  logic [15:0] refl_r;
  logic        tr_r;

  always_comb begin
    dsum     = 65'(f1_sqa_r) + 65'(f1_sqb_r) + (65'(1) << 46);
    csum     = 36'(f1_csum_r) + (36'(1) << 16);
    dval     = dsum[64:47];
    cval     = csum[35:17];
    tr_nxt   = 1'b0;
    refl_nxt = 16'hFFFF;
    case (f1_back_r.op)
      FRU_OP_DIELECTRIC: begin
        if (f1_back_r.tir) begin
          tr_nxt = 1'b1;
        end else if (dval <= 18'(16'hFFFF)) begin
          refl_nxt = dval[15:0];
        end
      end
      default: begin
        if (!f1_back_r.cz && cval <= 19'(16'hFFFF)) begin
          refl_nxt = cval[15:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      vld_r    <= 1'b0;
    end else begin
      f1_vld_r <= vld_i;
      vld_r    <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    refl_r <= refl_nxt;
    tr_r   <= tr_nxt;
  end

  assign vld_o  = vld_r;
  assign refl_o = refl_r;
  assign tr_o   = tr_r;

endmodule

### rtl/core/fresnel_reflectance_unit.sv
// fresnel_reflectance_unit: pipelined Fresnel reflectance for dielectrics and conductors
// top level; uses fru_pkg, fru_div_pipe, fru_isqrt_pipe, fru_cond_prep, fru_finish
//
// usage
//   an item transfers on a rising edge with start high and busy low; busy is
//   never raised, so a new item may transfer every cycle
//   in_op selects dielectric (0) or conductor (1); the index ports not used by
//   the selected mode are ignored
//   each result appears on out_reflectance / out_total_reflection for exactly one
//   cycle with out_valid high; the receiver has no way to hold it off
//   the pipeline depth from the transfer edge to the edge that takes the result is
//   independent of ETA_FRAC_BITS: 2 front stages, a 30 stage divider for the
//   transmitted cosine, a 16 stage square root, 5 ratio setup stages, a 33 stage
//   divider pair and 2 finishing stages
//   throughput is one item per cycle; results leave in transfer order
//   synchronous reset clears every valid bit, so items in flight are dropped
`timescale 1ns / 1ps

module fresnel_reflectance_unit import fru_pkg::*; #(
  parameter int ETA_FRAC_BITS = FRU_ETA_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_op,
  input  logic signed [15:0] in_cos_incident,
  input  logic [15:0]        in_eta_incident,
  input  logic [15:0]        in_eta_transmit,
  input  logic [15:0]        in_eta_real,
  input  logic [15:0]        in_absorption_k,
  output logic               out_valid,
  output logic [15:0]        out_reflectance,
  output logic               out_total_reflection
);

  localparam int MW  = fru_mag_w(ETA_FRAC_BITS);
  localparam int DW  = 2 * MW + 1;
  localparam int LAT = FRU_FRONT_STAGES + FRU_QW1 + FRU_RW + FRU_PREP_STAGES + FRU_QW2
                     + FRU_FIN_STAGES;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // front stage 1: squares
  logic [15:0] ci;
  logic        s1_vld_r;
  fru_front_t  s1_f_r;
  logic [31:0] s1_c2_r, s1_ei2_r, s1_et2_r;

  assign ci = in_cos_incident[15] ? 16'($unsigned(-in_cos_incident))
                                  : $unsigned(in_cos_incident);

  // front stage 2: ei^2 * sin^2
  logic        s2_vld_r;
  fru_front_t  s2_f_r;
  logic [61:0] s2_lhs_r;
  logic [31:0] s2_et2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_f_r.op  <= fru_op_t'(in_op);
    s1_f_r.tir <= 1'b0;
    s1_f_r.c   <= in_cos_incident;
    s1_f_r.ei  <= in_eta_incident;
    s1_f_r.et  <= in_eta_transmit;
    s1_f_r.er  <= in_eta_real;
    s1_f_r.k   <= in_absorption_k;
    s1_c2_r    <= 32'(ci) * 32'(ci);
    s1_ei2_r   <= 32'(in_eta_incident) * 32'(in_eta_incident);
    s1_et2_r   <= 32'(in_eta_transmit) * 32'(in_eta_transmit);
    s2_f_r     <= s1_f_r;
    s2_lhs_r   <= 62'(64'(s1_ei2_r) * 64'(32'h4000_0000 - s1_c2_r));
    s2_et2_r   <= s1_et2_r;
  end

  fru_front_t d1_side;
  always_comb begin
    d1_side     = s2_f_r;
    d1_side.tir = s2_lhs_r >= {s2_et2_r, 30'b0};
  end

  logic               q1_vld;
  logic [FRU_QW1-1:0] q1;
  fru_front_t         q1_side;

  fru_div_pipe #(
    .DW (32),
    .QW (FRU_QW1),
    .SW (FRU_FRONT_W)
  ) u_div_sin (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (s2_vld_r),
    .num_i  (s2_lhs_r),
    .den_i  (s2_et2_r),
    .side_i (d1_side),
    .vld_o  (q1_vld),
    .quo_o  (q1),
    .side_o (q1_side)
  );

  logic [2*FRU_RW-1:0] rad;
  logic                rt_vld;
  logic [FRU_RW-1:0]   cost;
  fru_front_t          rt_side;

  assign rad = 32'h4000_0000 - 32'(q1);

  fru_isqrt_pipe #(
    .RW (FRU_RW),
    .SW (FRU_FRONT_W)
  ) u_sqrt_cos (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (q1_vld),
    .rad_i  (rad),
    .side_i (q1_side),
    .vld_o  (rt_vld),
    .root_o (cost),
    .side_o (rt_side)
  );

  logic                  pr_vld;
  logic [DW+FRU_QW2-1:0] num_a, num_b;
  logic [DW-1:0]         den_a, den_b;
  fru_back_t             pr_back;

  fru_cond_prep #(
    .ETA_FRAC_BITS (ETA_FRAC_BITS)
  ) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (rt_vld),
    .cost_i  (cost),
    .front_i (rt_side),
    .vld_o   (pr_vld),
    .num_a_o (num_a),
    .den_a_o (den_a),
    .num_b_o (num_b),
    .den_b_o (den_b),
    .back_o  (pr_back)
  );

  logic [FRU_QW2-1:0] qa, qb;
  logic               qb_vld;
  fru_back_t          qb_back;

  fru_div_pipe #(
    .DW (DW),
    .QW (FRU_QW2),
    .SW (1)
  ) u_div_a (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (pr_vld),
    .num_i  (num_a),
    .den_i  (den_a),
    .side_i (1'b0),
    .vld_o  (),
    .quo_o  (qa),
    .side_o ()
  );

  fru_div_pipe #(
    .DW (DW),
    .QW (FRU_QW2),
    .SW (FRU_BACK_W)
  ) u_div_b (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (pr_vld),
    .num_i  (num_b),
    .den_i  (den_b),
    .side_i (pr_back),
    .vld_o  (qb_vld),
    .quo_o  (qb),
    .side_o (qb_back)
  );

  fru_finish u_finish (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (qb_vld),
    .qa_i   (qa),
    .qb_i   (qb),
    .back_i (qb_back),
    .vld_o  (out_valid),
    .refl_o (out_reflectance),
    .tr_o   (out_total_reflection)
  );

  // every result comes from an input transfer, and every transfer gives a result
  a_out_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result without a matching input transfer");

  a_in_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("input transfer produced no result");

  a_cond_no_tir: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == FRU_OP_CONDUCTOR) |-> ##LAT !out_total_reflection)
    else $error("total reflection flagged for a conductor item");

  a_zero_et_tir: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == FRU_OP_DIELECTRIC && in_eta_transmit == 16'd0)
      |-> ##LAT (out_total_reflection && out_reflectance == 16'hFFFF))
    else $error("zero transmitted index did not give total reflection");

endmodule
